// File: hw/rtl/dps_pkg.sv
// Shared types, codes and constants of the dynamic priority scheduler.
package dps_pkg;

   localparam int MAX_PROCS_DEFAULT = 16;
   localparam int QUEUE_DEPTH = 2;

   localparam int ID_W = 16;
   localparam int TIME_W = 8;
   localparam int PRIO_W = 9;
   localparam int ORDER_W = 32;
   localparam int CLOCK_W = 20;
   localparam int STATUS_W = 3;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 64;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [TIME_W-1:0] PRIO_BASE_RESET = 8'd50;
   localparam logic [CSR_ADDR_W-3:0] REG_PRIORITY_BASE = '0;
   localparam logic signed [PRIO_W-1:0] PRIO_MIN = {1'b1, {(PRIO_W-1){1'b0}}};

   typedef enum logic [STATUS_W-1:0] {
      ST_ADDED = 3'd0,
      ST_DUP   = 3'd1,
      ST_FULL  = 3'd2,
      ST_ZERO  = 3'd3,
      ST_RAN   = 3'd4,
      ST_DONE  = 3'd5,
      ST_IDLE  = 3'd6
   } status_type;

   typedef enum logic [1:0] {
      KIND_ADD  = 2'd0,
      KIND_ZERO = 2'd1,
      KIND_TICK = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type          kind;
      logic [ID_W-1:0]   proc_id;
      logic [TIME_W-1:0] need_time;
   } item_type;

   typedef struct packed {
      logic [ID_W-1:0]          proc_id;
      logic signed [PRIO_W-1:0] prio;
      logic [TIME_W-1:0]        remaining;
      logic [TIME_W-1:0]        used;
      logic [ORDER_W-1:0]       order;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

// File: hw/rtl/dynamic_priority_scheduler.sv
// An add or tick request is taken from the queue while idle, scans the whole table and then
// finishes once the result register is free; an add with zero need skips the scan.
// The engine works on one request at a time: the next one is taken after the last has
// finished. The scan reads one entry per cycle through the single RAM read port.
// Reset is synchronous: queue, valid bits, clock and order counter clear at once,
// and priority_base returns to 50; the table needs no clearing pass.
module dynamic_priority_scheduler import dps_pkg::*; #(
   parameter int MAX_PROCS = MAX_PROCS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // proc_id [15:0], need_time [23:16]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // op [0]
   input  logic [0:0]            req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // ran_id [15:0], remaining [23:16], priority_now [32:24], used_time [40:33],
   // turnaround [60:41], zero [63:61]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // status [2:0]
   output logic [STATUS_W-1:0]   rsp_tuser,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic [TIME_W-1:0] priority_base_ff, priority_base_in;
   logic              reg_sel;
   logic              item_valid;
   item_type          item;
   logic              item_pop;

   assign csr_pready = 1'b1;
   assign reg_sel    = (csr_paddr[CSR_ADDR_W-1:2] == REG_PRIORITY_BASE);

   always_comb begin
      priority_base_in = priority_base_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready && reg_sel) begin
         priority_base_in = csr_pwdata[TIME_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         priority_base_ff <= PRIO_BASE_RESET;
      end else begin
         priority_base_ff <= priority_base_in;
      end
   end

   assign csr_prdata = reg_sel ? {{(CSR_DATA_W - TIME_W){1'b0}}, priority_base_ff} : '0;

   dps_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop)
   );

   dps_back #(
      .MAX_PROCS(MAX_PROCS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .priority_base (priority_base_ff),
      .item_valid    (item_valid),
      .item          (item),
      .item_pop      (item_pop),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser)
   );

endmodule

// File: hw/rtl/dps_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module dps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/dps_front.sv
// Front end: accepts requests, classifies them and holds them in a short queue.
module dps_front import dps_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [0:0]            req_tuser,
   output logic                  item_valid,
   output item_type              item,
   input  logic                  item_pop
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   item_type         queue_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   item_type         classified;
   logic             push;

   always_comb begin
      classified.proc_id   = req_tdata[ID_W-1:0];
      classified.need_time = req_tdata[ID_W+TIME_W-1:ID_W];
      if (req_tuser[0]) begin
         classified.kind = KIND_TICK;
      end else if (classified.need_time == '0) begin
         classified.kind = KIND_ZERO;
      end else begin
         classified.kind = KIND_ADD;
      end
   end

   assign req_tready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign push       = req_tvalid && req_tready;
   assign item_valid = (count_ff != '0);
   assign item       = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (item_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !item_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && item_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         queue_ff[wr_ptr_ff] <= classified;
      end
   end

endmodule

// File: hw/rtl/dps_back.sv
// Back end: scans the process table for adds and ticks, adds, updates or retires an entry and registers the result.
module dps_back import dps_pkg::*; #(
   parameter int MAX_PROCS = MAX_PROCS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [TIME_W-1:0]     priority_base,
   input  logic                  item_valid,
   input  item_type              item,
   output logic                  item_pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [STATUS_W-1:0]   rsp_tuser
);

   localparam int IDX_W = $clog2(MAX_PROCS);
   localparam int CNT_W = $clog2(MAX_PROCS + 1);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_SCAN = 3'b010,
      S_DONE = 3'b100
   } state_type;

   state_type               state_ff, state_in;
   item_type                cur_ff, cur_in;
   logic [CNT_W-1:0]        scan_ctr_ff, scan_ctr_in;
   logic                    chk_vld_ff, chk_vld_in;
   logic [IDX_W-1:0]        chk_idx_ff, chk_idx_in;
   logic                    hit_ff, hit_in;
   logic [IDX_W-1:0]        hit_idx_ff, hit_idx_in;
   entry_type               best_ff, best_in;
   logic                    free_found_ff, free_found_in;
   logic [IDX_W-1:0]        free_idx_ff, free_idx_in;
   logic [MAX_PROCS-1:0]    valid_ff, valid_in;
   logic [ORDER_W-1:0]      order_ff, order_in;
   logic [CLOCK_W-1:0]      clock_ff, clock_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   status_type              rsp_status_ff, rsp_status_in;
   logic [RSP_DATA_W-1:0]   rsp_data_ff, rsp_data_in;

   logic                    rd_en;
   logic [IDX_W-1:0]        rd_addr;
   logic [ENTRY_W-1:0]      rd_data;
   logic                    wr_en;
   logic [IDX_W-1:0]        wr_addr;
   entry_type               wr_entry;
   entry_type               ent;
   logic                    ent_valid;
   logic                    last_chk;
   logic                    better;
   logic                    can_load;
   logic                    done_fire;
   logic                    retire;
   logic [TIME_W-1:0]       new_rem;
   logic [TIME_W-1:0]       new_used;
   logic signed [PRIO_W-1:0] new_prio;
   logic [CLOCK_W-1:0]      next_clock;

   dps_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(MAX_PROCS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_en     = (state_ff == S_SCAN) && (scan_ctr_ff < CNT_W'(MAX_PROCS));
   assign rd_addr   = scan_ctr_ff[IDX_W-1:0];
   assign ent       = entry_type'(rd_data);
   assign ent_valid = valid_ff[chk_idx_ff];
   assign last_chk  = chk_vld_ff && (chk_idx_ff == IDX_W'(MAX_PROCS - 1));
   assign better    = !hit_ff || (ent.prio > best_ff.prio) ||
                      ((ent.prio == best_ff.prio) && (ent.order < best_ff.order));
   assign can_load  = !rsp_valid_ff || rsp_tready;
   assign done_fire = (state_ff == S_DONE) && can_load;
   assign new_rem   = best_ff.remaining - 1'b1;
   assign new_used  = best_ff.used + 1'b1;
   assign new_prio  = (best_ff.prio == PRIO_MIN) ? PRIO_MIN : best_ff.prio - PRIO_W'(1);
   assign next_clock = clock_ff + 1'b1;
   assign retire    = (cur_ff.kind == KIND_TICK) && hit_ff && (new_rem == '0);
   assign item_pop  = (state_ff == S_IDLE) && item_valid;

   always_comb begin
      state_in      = state_ff;
      cur_in        = cur_ff;
      scan_ctr_in   = scan_ctr_ff;
      chk_vld_in    = rd_en;
      chk_idx_in    = rd_addr;
      hit_in        = hit_ff;
      hit_idx_in    = hit_idx_ff;
      best_in       = best_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      valid_in      = valid_ff;
      order_in      = order_ff;
      clock_in      = clock_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_data_in   = rsp_data_ff;
      wr_en         = 1'b0;
      wr_addr       = free_idx_ff;
      wr_entry      = best_ff;

      case (state_ff)
         S_IDLE: begin
            if (item_valid) begin
               cur_in        = item;
               scan_ctr_in   = '0;
               hit_in        = 1'b0;
               free_found_in = 1'b0;
               state_in      = (item.kind == KIND_ZERO) ? S_DONE : S_SCAN;
            end
         end
         S_SCAN: begin
            if (rd_en) begin
               scan_ctr_in = scan_ctr_ff + 1'b1;
            end
            if (chk_vld_ff) begin
               if (cur_ff.kind == KIND_TICK) begin
                  if (ent_valid && better) begin
                     hit_in     = 1'b1;
                     hit_idx_in = chk_idx_ff;
                     best_in    = ent;
                  end
               end else begin
                  if (ent_valid && (ent.proc_id == cur_ff.proc_id)) begin
                     hit_in = 1'b1;
                  end
                  if (!ent_valid && !free_found_ff) begin
                     free_found_in = 1'b1;
                     free_idx_in   = chk_idx_ff;
                  end
               end
            end
            if (last_chk) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (can_load) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               case (cur_ff.kind)
                  KIND_ZERO: begin
                     rsp_status_in = ST_ZERO;
                  end
                  KIND_ADD: begin
                     if (hit_ff) begin
                        rsp_status_in = ST_DUP;
                     end else if (!free_found_ff) begin
                        rsp_status_in = ST_FULL;
                     end else begin
                        rsp_status_in      = ST_ADDED;
                        wr_en              = 1'b1;
                        wr_addr            = free_idx_ff;
                        wr_entry.proc_id   = cur_ff.proc_id;
                        wr_entry.prio      = $signed({1'b0, priority_base}) -
                                             $signed({1'b0, cur_ff.need_time});
                        wr_entry.remaining = cur_ff.need_time;
                        wr_entry.used      = '0;
                        wr_entry.order     = order_ff;
                        valid_in[free_idx_ff] = 1'b1;
                        order_in           = order_ff + 1'b1;
                     end
                  end
                  KIND_TICK: begin
                     if (!hit_ff) begin
                        rsp_status_in = ST_IDLE;
                     end else begin
                        clock_in    = next_clock;
                        rsp_data_in = {{(RSP_DATA_W - CLOCK_W - 2*TIME_W - PRIO_W - ID_W){1'b0}},
                                       (retire ? next_clock : {CLOCK_W{1'b0}}),
                                       new_used, new_prio, new_rem, best_ff.proc_id};
                        if (retire) begin
                           rsp_status_in = ST_DONE;
                           valid_in[hit_idx_ff] = 1'b0;
                        end else begin
                           rsp_status_in      = ST_RAN;
                           wr_en              = 1'b1;
                           wr_addr            = hit_idx_ff;
                           wr_entry.prio      = new_prio;
                           wr_entry.remaining = new_rem;
                           wr_entry.used      = new_used;
                           wr_entry.order     = order_ff;
                           order_in           = order_ff + 1'b1;
                        end
                     end
                  end
                  default: begin
                     rsp_status_in = ST_IDLE;
                  end
               endcase
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         chk_vld_ff   <= 1'b0;
         valid_ff     <= '0;
         order_ff     <= '0;
         clock_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         chk_vld_ff   <= chk_vld_in;
         valid_ff     <= valid_in;
         order_ff     <= order_in;
         clock_ff     <= clock_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_ff        <= cur_in;
      scan_ctr_ff   <= scan_ctr_in;
      chk_idx_ff    <= chk_idx_in;
      hit_ff        <= hit_in;
      hit_idx_ff    <= hit_idx_in;
      best_ff       <= best_in;
      free_found_ff <= free_found_in;
      free_idx_ff   <= free_idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;

`ifndef NO_ASSERTIONS
   a_pop_only_idle: assert property (@(posedge clock) disable iff (reset)
      item_pop |-> (state_ff == S_IDLE))
      else $error("Request taken from the queue while the engine is busy.");

   a_no_write_in_scan: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (!rd_en && (state_ff == S_DONE)))
      else $error("Table written outside the finishing step.");

   a_result_from_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff)) |-> ($past(state_ff) == S_DONE))
      else $error("Result appeared without a finishing step.");

   a_retire_clears: assert property (@(posedge clock) disable iff (reset)
      (done_fire && retire) |=> !valid_ff[$past(hit_idx_ff)])
      else $error("Finished process still marked as waiting.");
`endif

endmodule
